### rtl/assert_macros.svh
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while reset is low
`define DSA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("descriptor slot allocator assertion failed");

// property checked at every edge, reset included
`define DSA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("descriptor slot allocator assertion failed");

`endif

### rtl/dsa_pkg.sv
// types and constants of the descriptor slot allocator
`timescale 1ns / 1ps
package dsa_pkg;

  localparam int SLOTS_PER_BLOCK = 4;

  localparam logic [1:0] MODE_FREE  = 2'd0;
  localparam logic [1:0] MODE_SMALL = 2'd1;
  localparam logic [1:0] MODE_LARGE = 2'd2;

  localparam logic [SLOTS_PER_BLOCK-1:0] ALL_SLOTS_FREE = '1;
  localparam logic [SLOTS_PER_BLOCK-1:0] NEW_SMALL_MARKS = 4'b0111;
  localparam logic [1:0] LAST_SLOT = 2'd3;

  localparam logic [1:0] KIND_ALLOC_LARGE = 2'd0;
  localparam logic [1:0] KIND_ALLOC_SMALL = 2'd1;
  localparam logic [1:0] KIND_FREE_SMALL  = 2'd2;
  localparam logic [1:0] KIND_FREE_LARGE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BAD_FREE  = 2'd2;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [SLOTS_PER_BLOCK-1:0] marks;
  } entry_t;

  function automatic logic [1:0] first_free(input logic [SLOTS_PER_BLOCK-1:0] m);
    logic [1:0] s;
    if (m[0]) s = 2'd0;
    else if (m[1]) s = 2'd1;
    else if (m[2]) s = 2'd2;
    else s = 2'd3;
    return s;
  endfunction

endpackage

### rtl/dsa_table.sv
// block table memory: one write port, one registered read port
`timescale 1ns / 1ps
module dsa_table #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  dsa_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output dsa_pkg::entry_t rdata
);
  import dsa_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/descriptor_slot_allocator.sv
// descriptor slot allocator top level: request sequencer over the block table
//
// input channel in_valid/in_ready carries one request word: kind, block_index,
// slot_index. output channel out_valid/out_ready returns one result word per
// request: status, granted_block, granted_slot.
// one request is worked at a time; in_ready is high only while the sequencer
// is idle. the block table sits in a single-port-read memory, so every request
// that reads the table costs reads of that one port.
// allocate requests scan the table from the top index down, one entry per
// cycle; a hit stops the scan, else it runs down to index 0.
// free requests read and check one entry and write it back if the free is
// valid; a block index beyond the pool goes straight to the result.
// after reset the table is cleared one entry a cycle, with in_ready low.
// a finished result waits in the output register while the receiver stalls;
// the next request may already be accepted and worked, and its result waits
// in the sequencer until the output register is free.
`timescale 1ns / 1ps
module descriptor_slot_allocator #(
  parameter int NUM_BLOCKS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [5:0] block_index,
  input  logic [1:0] slot_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [5:0] granted_block,
  output logic [1:0] granted_slot
);
  import dsa_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_FREE_RD, S_FREE_EVAL, S_RESULT
  } state_t;

  state_t        state;
  logic [AW-1:0] addr;
  logic [AW-1:0] addr_q;
  logic          issue;
  logic          rd_valid;
  logic [1:0]    op;
  logic [1:0]    slot;
  logic          have_free;
  logic [AW-1:0] lowest_free;
  logic [1:0]    res_status;
  logic [AW-1:0] res_blk;
  logic [1:0]    res_slot;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  entry_t        rdata;

  logic          in_range;
  logic          large_hit;
  logic          small_hit;
  logic          cur_free;
  logic          last_entry;
  logic [1:0]    hit_slot;
  logic          out_free;

  dsa_table #(.DEPTH(NUM_BLOCKS), .AW(AW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  assign in_ready   = (state == S_IDLE);
  assign in_range   = (32'(block_index) < NUM_BLOCKS);
  assign cur_free   = (rdata.mode == MODE_FREE);
  assign large_hit  = cur_free || (rdata.mode == MODE_SMALL && rdata.marks == ALL_SLOTS_FREE);
  assign small_hit  = (rdata.mode == MODE_SMALL) && (rdata.marks != '0);
  assign hit_slot   = first_free(rdata.marks);
  assign last_entry = (addr_q == '0);
  assign out_free   = !out_valid || out_ready;

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = '0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = addr;
      end
      S_SCAN: begin
        if (rd_valid) begin
          if (op == KIND_ALLOC_LARGE) begin
            if (large_hit) begin
              we    = 1'b1;
              wdata = '{mode: MODE_LARGE, marks: '0};
            end
          end else if (small_hit) begin
            we          = 1'b1;
            wdata.mode  = MODE_SMALL;
            wdata.marks = rdata.marks & ~(4'b0001 << hit_slot);
          end else if (last_entry && (cur_free || have_free)) begin
            we    = 1'b1;
            waddr = cur_free ? addr_q : lowest_free;
            wdata = '{mode: MODE_SMALL, marks: NEW_SMALL_MARKS};
          end
        end
      end
      S_FREE_EVAL: begin
        waddr = addr;
        if (op == KIND_FREE_SMALL) begin
          if (rdata.mode == MODE_SMALL && !rdata.marks[slot]) begin
            we          = 1'b1;
            wdata.mode  = MODE_SMALL;
            wdata.marks = rdata.marks | (4'b0001 << slot);
          end
        end else if (!cur_free) begin
          we          = 1'b1;
          wdata.mode  = MODE_FREE;
          wdata.marks = rdata.marks;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      issue     <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op        <= kind;
            slot      <= slot_index;
            have_free <= 1'b0;
            rd_valid  <= 1'b0;
            res_blk   <= '0;
            res_slot  <= 2'd0;
            if (kind == KIND_ALLOC_LARGE || kind == KIND_ALLOC_SMALL) begin
              res_status <= ST_OK;
              addr       <= LAST_ADDR;
              issue      <= 1'b1;
              state      <= S_SCAN;
            end else if (in_range) begin
              res_status <= ST_OK;
              addr       <= AW'(block_index);
              state      <= S_FREE_RD;
            end else begin
              res_status <= ST_BAD_FREE;
              state      <= S_RESULT;
            end
          end
        end
        S_SCAN: begin
          addr_q   <= addr;
          rd_valid <= issue;
          if (issue) begin
            if (addr == '0) begin
              issue <= 1'b0;
            end else begin
              addr <= addr - 1'b1;
            end
          end
          if (rd_valid) begin
            if (op == KIND_ALLOC_LARGE) begin
              if (large_hit) begin
                res_blk <= addr_q;
                state   <= S_RESULT;
              end else if (last_entry) begin
                res_status <= ST_EXHAUSTED;
                state      <= S_RESULT;
              end
            end else begin
              if (cur_free) begin
                have_free   <= 1'b1;
                lowest_free <= addr_q;
              end
              if (small_hit) begin
                res_blk  <= addr_q;
                res_slot <= hit_slot;
                state    <= S_RESULT;
              end else if (last_entry) begin
                state <= S_RESULT;
                if (cur_free) begin
                  res_blk  <= addr_q;
                  res_slot <= LAST_SLOT;
                end else if (have_free) begin
                  res_blk  <= lowest_free;
                  res_slot <= LAST_SLOT;
                end else begin
                  res_status <= ST_EXHAUSTED;
                end
              end
            end
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_EVAL;
        end
        S_FREE_EVAL: begin
          state <= S_RESULT;
          if (op == KIND_FREE_SMALL) begin
            if (rdata.mode != MODE_SMALL || rdata.marks[slot]) begin
              res_status <= ST_BAD_FREE;
            end
          end else if (cur_free) begin
            res_status <= ST_BAD_FREE;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            status        <= res_status;
            granted_block <= 6'(res_blk);
            granted_slot  <= res_slot;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/dsa_checker.sv
// port-level checker for the descriptor slot allocator, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] kind,
  input logic [5:0] block_index,
  input logic [1:0] slot_index,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [5:0] granted_block,
  input logic [1:0] granted_slot
);
  import dsa_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  `DSA_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> !in_ready)
  `DSA_ASSERT(a_one_at_a_time, clk, rst, in_fire |=> !in_ready)
  `DSA_ASSERT(a_in_hold, clk, rst,
    (in_valid && !in_ready) |=> (in_valid && $stable(kind) && $stable(block_index) && $stable(slot_index)))
  `DSA_ASSERT(a_no_grant_on_fail, clk, rst,
    (out_valid && status != ST_OK) |-> (granted_block == 6'd0 && granted_slot == 2'd0))
  `DSA_ASSERT(a_out_hold, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(granted_block)))

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (.*);
